// ===== design/uvn_pkg.sv =====
// Shared constants for the 2-D vector normalization pipeline.
`default_nettype none
package uvn_pkg;
  localparam int unsigned CompW       = 16;  // input component width
  localparam int unsigned UnitW       = 16;  // output component width
  localparam int unsigned QuotW       = 16;  // rounded quotient magnitude, 0..32768
  localparam int unsigned SumW        = 32;  // x^2 + y^2
  localparam int unsigned AccAW       = 64;  // u^2 * s
  localparam int unsigned AccBW       = 49;  // u * s
  localparam int unsigned FracBitsDef = 14;
endpackage
`default_nettype wire

// ===== design/unit_vector_normalize.sv =====
// Pipelined 2-D vector normalization to signed fixed point.
//
// Channel  | Dir | Beat content (lowest bit first)
// s_axis   | in  | tdata: x_in[15:0], y_in[31:16]
// m_axis   | out | tdata: unit_x[15:0], unit_y[31:16]; tuser: ok
//
// One vector is taken every cycle unless a stalled output has filled the pipe.
// The depth is set by the quotient search: one result bit per stage, 16 stages,
// after an abs stage, a squaring stage and a sum stage, with an output register.
// Reset (rst_ni low) clears only the stage valid bits.
// Each stage holds while the stage after it is full and stalled; empty stages
// keep filling, so a stalled output does not stop intake until the pipe is full.
`default_nettype none
module unit_vector_normalize #(
  parameter int unsigned FRAC_BITS = uvn_pkg::FracBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // x_in[15:0], y_in[31:16]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // unit_x[15:0], unit_y[31:16]
  output logic             m_axis_tuser    // ok
);
  localparam int unsigned CW  = uvn_pkg::CompW;
  localparam int unsigned QW  = uvn_pkg::QuotW;
  localparam int unsigned SW  = uvn_pkg::SumW;
  localparam int unsigned AW  = uvn_pkg::AccAW;
  localparam int unsigned BW  = uvn_pkg::AccBW;
  localparam int unsigned RW  = 2 * FRAC_BITS + SW + 2;      // 4 * c^2 * 2^(2F)
  localparam int unsigned MW  = (RW > AW + 2) ? RW : AW + 2; // compare width
  localparam int unsigned NB  = QW;                          // search stages
  localparam int unsigned NS  = NB + 4;                      // all stages
  localparam int unsigned SIX = 0;  // abs stage
  localparam int unsigned SSQ = 1;  // squares stage
  localparam int unsigned SSM = 2;  // sum stage, search input
  localparam int unsigned SOUT = NS - 1;

  typedef struct packed {
    logic [QW-1:0] q;
    logic [AW-1:0] a;  // (2q)^2 * s
    logic [BW-1:0] b;  // 2q * s
    logic [RW-1:0] r;  // 4 * c^2 * 2^(2F)
    logic          neg;
  } srch_t;

  // Per-stage valid and advance
  logic [NS-1:0] v_q;
  logic [NS-1:0] adv;

  always_comb begin
    adv[SOUT] = !v_q[SOUT] || m_axis_tready;
    for (int i = int'(SOUT) - 1; i >= 0; i--) begin
      adv[i] = !v_q[i] || adv[i+1];
    end
  end

  assign s_axis_tready = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) begin
        v_q[0] <= s_axis_tvalid;
      end
      for (int i = 1; i < int'(NS); i++) begin
        if (adv[i]) begin
          v_q[i] <= v_q[i-1];
        end
      end
    end
  end

  // Stage 0: magnitudes and signs
  logic signed [CW-1:0] x_in, y_in;
  logic [CW-1:0] ax_d, ay_d, ax_q, ay_q;
  logic          nx_q, ny_q;
  assign x_in = s_axis_tdata[CW-1:0];
  assign y_in = s_axis_tdata[2*CW-1:CW];
  assign ax_d = x_in[CW-1] ? (~x_in + 1'b1) : x_in;
  assign ay_d = y_in[CW-1] ? (~y_in + 1'b1) : y_in;

  always_ff @(posedge clk_i) begin
    if (adv[SIX]) begin
      ax_q <= ax_d;
      ay_q <= ay_d;
      nx_q <= x_in[CW-1];
      ny_q <= y_in[CW-1];
    end
  end

  // Stage 1: squares
  logic [2*CW-1:0] xsq_q, ysq_q;
  logic            nx1_q, ny1_q;
  always_ff @(posedge clk_i) begin
    if (adv[SSQ]) begin
      xsq_q <= ax_q * ax_q;
      ysq_q <= ay_q * ay_q;
      nx1_q <= nx_q;
      ny1_q <= ny_q;
    end
  end

  // One quotient bit per stage, MSB first. With u = 2q, the test is
  // (u-1)^2 * s = u^2 s - 2 u s + s <= r, kept up to date by shifts and adds.
  function automatic srch_t srch_step(srch_t cur, logic [SW-1:0] s, int unsigned bit_pos);
    srch_t         nxt;
    logic [AW-1:0] a_try;
    logic [BW-1:0] b_try;
    logic [MW-1:0] lhs;
    nxt   = cur;
    a_try = cur.a + (AW'(cur.b) << (bit_pos + 2)) + (AW'(s) << (2 * bit_pos + 2));
    b_try = cur.b + (BW'(s) << (bit_pos + 1));
    lhs   = MW'(a_try) + MW'(s) - (MW'(b_try) << 1);
    if (!cur.q[QW-1] && (lhs <= MW'(cur.r))) begin
      nxt.q = cur.q | (QW'(1) << bit_pos);
      nxt.a = a_try;
      nxt.b = b_try;
    end
    return nxt;
  endfunction

  // Stage 2: sum of squares and scaled right-hand sides; then the search stages
  srch_t            sx_q [NB+1];
  srch_t            sy_q [NB+1];
  logic [SW-1:0]    s_q  [NB+1];

  always_ff @(posedge clk_i) begin
    if (adv[SSM]) begin
      s_q[0]      <= SW'(xsq_q) + SW'(ysq_q);
      sx_q[0].q   <= '0;
      sx_q[0].a   <= '0;
      sx_q[0].b   <= '0;
      sx_q[0].r   <= RW'(xsq_q) << (2 * FRAC_BITS + 2);
      sx_q[0].neg <= nx1_q;
      sy_q[0].q   <= '0;
      sy_q[0].a   <= '0;
      sy_q[0].b   <= '0;
      sy_q[0].r   <= RW'(ysq_q) << (2 * FRAC_BITS + 2);
      sy_q[0].neg <= ny1_q;
    end
    for (int k = 0; k < int'(NB); k++) begin
      if (adv[SSM+1+k]) begin
        sx_q[k+1] <= srch_step(sx_q[k], s_q[k], NB - 1 - k);
        sy_q[k+1] <= srch_step(sy_q[k], s_q[k], NB - 1 - k);
        s_q[k+1]  <= s_q[k];
      end
    end
  end

  // Output stage: sign, saturation, zero-length case
  function automatic logic [uvn_pkg::UnitW-1:0] to_unit(srch_t c);
    logic [uvn_pkg::UnitW-1:0] res;
    if (c.neg) begin
      res = ~c.q + 1'b1;
    end else if (c.q[QW-1]) begin
      res = {1'b0, {(uvn_pkg::UnitW-1){1'b1}}};
    end else begin
      res = c.q;
    end
    return res;
  endfunction

  logic [uvn_pkg::UnitW-1:0] ux_q, uy_q;
  logic                      ok_q;
  logic                      nz;
  assign nz = (s_q[NB] != '0);

  always_ff @(posedge clk_i) begin
    if (adv[SOUT]) begin
      ux_q <= nz ? to_unit(sx_q[NB]) : '0;
      uy_q <= nz ? to_unit(sy_q[NB]) : '0;
      ok_q <= nz;
    end
  end

  assign m_axis_tvalid = v_q[SOUT];
  assign m_axis_tdata  = {uy_q, ux_q};
  assign m_axis_tuser  = ok_q;

  // Checks
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("zero-length result with nonzero components");
  a_ok_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata != '0))
    else $error("normalized result with both components zero");
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("intake blocked while output is empty");
endmodule
`default_nettype wire

// ===== dv/unit_vector_normalize_tb.sv =====
// Self-checking testbench for the 2-D vector normalization pipeline.
`default_nettype none
module unit_vector_normalize_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FracBits = uvn_pkg::FracBitsDef;

  typedef struct packed {
    logic [15:0] ux;
    logic [15:0] uy;
    logic        ok;
  } unit_vec_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;

  unit_vec_t   unit_q[$];
  int          n_fail = 0;
  int          n_sent = 0;
  int          n_got = 0;
  bit          hold_off = 1'b0;

  unit_vector_normalize #(.FRAC_BITS(FracBits)) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // x_in[15:0], y_in[31:16]
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // unit_x[15:0], unit_y[31:16]
    .m_axis_tuser  (m_axis_tuser)    // ok
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Largest q <= 32768 with (2q-1)^2 * s <= 4 * c^2 * 2^(2F): rounded |c|*2^F/L
  function automatic logic [15:0] scaled_comp(input logic signed [15:0] c,
                                              input logic [31:0] s);
    logic [127:0] rhs;
    logic [127:0] lhs;
    logic [31:0]  mag;
    int unsigned  lo;
    int unsigned  hi;
    int unsigned  mid;
    lo = 0;
    hi = 32768;
    mag = (c < 0) ? -32'(c) : 32'(c);
    rhs = (128'(mag) * mag) << (2 * FracBits + 2);
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      lhs = 128'(2 * mid - 1) * (2 * mid - 1) * s;
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    if (c < 0) return 16'(-32'(lo));
    return (lo > 32767) ? 16'h7fff : 16'(lo);
  endfunction

  function automatic unit_vec_t normalize_vec(input logic signed [15:0] x,
                                              input logic signed [15:0] y);
    unit_vec_t   r;
    logic [31:0] s;
    s = 32'(32'sd0 + x * x) + 32'(32'sd0 + y * y);
    if (s == 0) begin
      r = '0;
    end else begin
      r.ux = scaled_comp(x, s);
      r.uy = scaled_comp(y, s);
      r.ok = 1'b1;
    end
    return r;
  endfunction

  // Drive one beat and wait for the handshake; valid stays high across back-to-back beats
  task automatic send_vec(input logic [15:0] x, input logic [15:0] y);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {y, x};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    unit_q.push_back(normalize_vec(x, y));
    n_sent++;
  endtask

  task automatic gap_maybe();
    int g;
    if ($urandom_range(0, 7) == 0) begin
      g = $urandom_range(1, 6);
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic idle_tx();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_directed();
    logic [15:0] v[10];
    v = '{16'h0000, 16'h0001, 16'hffff, 16'h7fff, 16'h8000, 16'h8001,
          16'h7ffe, 16'h0003, 16'hfffd, 16'h4000};
    send_vec(16'h0000, 16'h0000);  // zero length
    send_vec(16'h8000, 16'h8000);
    send_vec(16'h7fff, 16'h8000);
    send_vec(16'h8000, 16'h0000);
    send_vec(16'h0000, 16'h7fff);
    send_vec(16'h0003, 16'h0004);
    send_vec(16'hfffd, 16'hfffc);
    send_vec(16'h0001, 16'h0001);  // equal components
    for (int i = 0; i < 16; i++) send_vec(v[$urandom_range(0, 9)], v[$urandom_range(0, 9)]);
    idle_tx();
  endtask

  task automatic test_random();
    logic [15:0] x;
    logic [15:0] y;
    int          kind;
    for (int i = 0; i < 1000; i++) begin
      kind = $urandom_range(0, 3);
      x = 16'($urandom);
      y = 16'($urandom);
      if (kind == 1) begin
        x = 16'($signed(16'($urandom_range(0, 15))) - 8);
        y = 16'($signed(16'($urandom_range(0, 15))) - 8);
      end else if (kind == 2) begin
        y = 16'($urandom_range(0, 3) - 1);
      end
      send_vec(x, y);
      gap_maybe();
    end
    idle_tx();
  endtask

  // Output stalls long enough to fill the pipe while the sender keeps going
  task automatic test_backpressure();
    hold_off = 1'b1;
    for (int i = 0; i < 40; i++) send_vec(16'($urandom), 16'($urandom));
    idle_tx();
    hold_off = 1'b0;
  endtask

  // Receiver: its own random stall pattern, plus one long hold-off per request
  initial begin
    int hold;
    int phase;
    hold = 0;
    phase = 0;
    forever begin
      @(posedge clk_i);
      phase++;
      if (hold_off && hold == 0) begin
        hold = 60;
        hold_off = 1'b0;
      end
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else if ((phase / 64) % 3 == 0) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // Result checker
  initial begin
    unit_vec_t e;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        n_got++;
        if (unit_q.size() == 0) begin
          $display("%0t: unexpected result %h ok=%b", $time, m_axis_tdata, m_axis_tuser);
          n_fail++;
        end else begin
          e = unit_q.pop_front();
          if (m_axis_tdata[15:0] !== e.ux) begin
            $display("%0t: unit_x exp %h got %h", $time, e.ux, m_axis_tdata[15:0]);
            n_fail++;
          end
          if (m_axis_tdata[31:16] !== e.uy) begin
            $display("%0t: unit_y exp %h got %h", $time, e.uy, m_axis_tdata[31:16]);
            n_fail++;
          end
          if (m_axis_tuser !== e.ok) begin
            $display("%0t: ok exp %b got %b", $time, e.ok, m_axis_tuser);
            n_fail++;
          end
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("timeout");
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int w;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random();
    w = 0;
    while (unit_q.size() != 0 && w < 20000) begin
      @(posedge clk_i);
      w++;
    end
    repeat (40) @(posedge clk_i);
    if (unit_q.size() != 0) begin
      $display("%0d results never arrived", unit_q.size());
      n_fail++;
    end
    $display("Sent %0d vectors (extremes, zero length, small and axis-aligned, random),",
             n_sent);
    $display("checked %0d results under input gaps and output stalls.", n_got);
    if (n_fail == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
